// ===== rtl/cfpe_pkg.sv =====
package cfpe_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hAA;
  localparam logic [7:0] MIN_ENC_LEN  = 8'd4;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDRESS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_COMMAND = 8'd1;

  localparam logic [7:0] HOST_ADDRESS_RST    = 8'd2;
  localparam logic [7:0] ENCODER_COMMAND_RST = 8'd161;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SOURCE,
    PH_DEST,
    PH_COMMAND,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_SUM_CHECK,
    PH_ADD_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_CHECK_FAIL = 3'd1,
    ST_WRONG_DEST = 3'd2,
    ST_OTHER_CMD  = 3'd3,
    ST_SHORT      = 3'd4
  } status_e;

  typedef struct packed {
    logic            sum_ok;
    logic [7:0]      source;
    logic [7:0]      dest;
    logic [7:0]      command;
    logic [7:0]      length;
    logic [3:0][7:0] payload;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0] host_address;
    logic [7:0] encoder_command;
  } cfg_t;

endpackage

// ===== rtl/cfpe_if.sv =====
interface cfpe_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface cfpe_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         source_address;
  logic [7:0]         command_code;
  logic [7:0]         payload_length;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;

  modport source (output valid, output status, output source_address, output command_code,
                  output payload_length, output left_count, output right_count,
                  input ready);
  modport sink (input valid, input status, input source_address, input command_code,
                input payload_length, input left_count, input right_count,
                output ready);
endinterface

// ===== rtl/cfpe_front.sv =====
module cfpe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cfpe_rx_if.sink               rx_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cfpe_pkg::frame_rec_t  q_rec_o
);
  import cfpe_pkg::*;

  phase_e          phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      src_q, src_d;
  logic [7:0]      dst_q, dst_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      sos_q, sos_d;
  logic [7:0]      chk_q, chk_d;
  logic [3:0][7:0] pay_q, pay_d;

  logic       acc;
  logic [7:0] b;
  logic [7:0] sum_add;
  logic [7:0] sos_add;
  logic [7:0] cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      len_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      cmd_q   <= '0;
      sum_q   <= '0;
      sos_q   <= '0;
      chk_q   <= '0;
      pay_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      cmd_q   <= cmd_d;
      sum_q   <= sum_d;
      sos_q   <= sos_d;
      chk_q   <= chk_d;
      pay_q   <= pay_d;
    end
  end

  assign rx_i.ready = (phase_q != PH_ADD_CHECK) || !q_full_i;
  assign acc        = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign sum_add    = sum_q + b;
  assign sos_add    = sos_q + sum_add;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    src_d    = src_q;
    dst_d    = dst_q;
    cmd_d    = cmd_q;
    sum_d    = sum_q;
    sos_d    = sos_q;
    chk_d    = chk_q;
    pay_d    = pay_q;
    q_push_o = 1'b0;
    if (acc) begin
      case (phase_q)
        PH_HUNT: begin
          if (b == FRAME_HEADER) begin
            sum_d   = FRAME_HEADER;
            sos_d   = FRAME_HEADER;
            cnt_d   = '0;
            phase_d = PH_SOURCE;
          end
        end
        PH_SOURCE: begin
          src_d   = b;
          sum_d   = sum_add;
          sos_d   = sos_add;
          phase_d = PH_DEST;
        end
        PH_DEST: begin
          dst_d   = b;
          sum_d   = sum_add;
          sos_d   = sos_add;
          phase_d = PH_COMMAND;
        end
        PH_COMMAND: begin
          cmd_d   = b;
          sum_d   = sum_add;
          sos_d   = sos_add;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d   = b;
          sum_d   = sum_add;
          sos_d   = sos_add;
          cnt_d   = '0;
          phase_d = (b == 8'd0) ? PH_SUM_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_d = sum_add;
          sos_d = sos_add;
          if (cnt_q < MIN_ENC_LEN) begin
            pay_d[cnt_q[1:0]] = b;
          end
          if (cnt_inc >= len_q) begin
            cnt_d   = '0;
            phase_d = PH_SUM_CHECK;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_SUM_CHECK: begin
          chk_d   = b;
          phase_d = PH_ADD_CHECK;
        end
        PH_ADD_CHECK: begin
          q_push_o = 1'b1;
          cnt_d    = '0;
          phase_d  = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    q_rec_o.sum_ok  = (chk_q == sum_q) && (b == sos_q);
    q_rec_o.source  = src_q;
    q_rec_o.dest    = dst_q;
    q_rec_o.command = cmd_q;
    q_rec_o.length  = len_q;
    q_rec_o.payload = pay_q;
  end

endmodule

// ===== rtl/cfpe_queue.sv =====
module cfpe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cfpe_pkg::frame_rec_t  rec_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output cfpe_pkg::frame_rec_t  rec_o
);
  import cfpe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  frame_rec_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

// ===== rtl/cfpe_back.sv =====
module cfpe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfpe_pkg::cfg_t        cfg_i,
  input  logic                  q_empty_i,
  input  cfpe_pkg::frame_rec_t  q_rec_i,
  output logic                  q_pop_o,
  cfpe_res_if.source            res_o
);
  import cfpe_pkg::*;

  logic        valid_q, valid_d;
  status_e     st_q, st_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [15:0] right_q, right_d;
  status_e     status;

  always_comb begin
    if (!q_rec_i.sum_ok) begin
      status = ST_CHECK_FAIL;
    end else if (q_rec_i.dest != cfg_i.host_address) begin
      status = ST_WRONG_DEST;
    end else if (q_rec_i.command != cfg_i.encoder_command) begin
      status = ST_OTHER_CMD;
    end else if (q_rec_i.length < MIN_ENC_LEN) begin
      status = ST_SHORT;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  assign q_pop_o = !q_empty_i && (!valid_q || res_o.ready);

  always_comb begin
    valid_d = valid_q;
    st_d    = st_q;
    src_d   = src_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    left_d  = left_q;
    right_d = right_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
      st_d    = status;
      src_d   = q_rec_i.source;
      cmd_d   = q_rec_i.command;
      len_d   = q_rec_i.length;
      if (status == ST_ACCEPTED) begin
        left_d  = {q_rec_i.payload[0], q_rec_i.payload[1]};
        right_d = {q_rec_i.payload[2], q_rec_i.payload[3]};
      end
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    src_q <= src_d;
    cmd_q <= cmd_d;
    len_q <= len_d;
  end

  assign res_o.valid          = valid_q;
  assign res_o.status         = 3'(st_q);
  assign res_o.source_address = src_q;
  assign res_o.command_code   = cmd_q;
  assign res_o.payload_length = len_q;
  assign res_o.left_count     = signed'(left_q);
  assign res_o.right_count    = signed'(right_q);

endmodule

// ===== rtl/checked_frame_parser_encoder_counts.sv =====
// Serial frame parser for encoder count reports. Received bytes enter on rx_i, one per
// transaction, and the block takes one byte every cycle except while the second check byte
// is held off by a full queue. It hunts for the 0xAA header, then reads source, destination,
// command, length, payload and two check bytes (8-bit sum and sum of sums over header
// through payload). After the second check byte the frame goes through the QUEUE_DEPTH-entry
// queue and the output register of the result stage, and one result leaves on res_o with a
// status (0 counts accepted, 1 check mismatch, 2 wrong destination, 3 other command, 4 short
// payload) and the held left/right counts, which update from payload bytes 0..3 (big-endian,
// signed) only on an accepted frame. The result stage drains one frame a cycle into that
// register while it is empty or res_o is ready. host_address and encoder_command are to be
// written on cfg_i (index 0 and 1) only while the block is idle; the block does not enforce
// this. Other indices are ignored.
module checked_frame_parser_encoder_counts #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfpe_rx_if.sink    rx_i,
  cfpe_cfg_if.sink   cfg_i,
  cfpe_res_if.source res_o
);
  import cfpe_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  frame_rec_t push_rec;
  frame_rec_t pop_rec;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HOST_ADDRESS:    cfg_d.host_address    = cfg_i.data;
        CFG_ENCODER_COMMAND: cfg_d.encoder_command = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.host_address    <= HOST_ADDRESS_RST;
      cfg_q.encoder_command <= ENCODER_COMMAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfpe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_rec_o  (push_rec)
  );

  cfpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rec_o   (pop_rec)
  );

  cfpe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_rec_i   (pop_rec),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
